FILE: rtl/spcs_pkg.sv
package spcs_pkg;

    localparam logic [7:0] CODE_FWD = 8'hAA;
    localparam logic [7:0] CODE_REV = 8'hBB;

    localparam logic [1:0] DIR_NONE    = 2'd0;
    localparam logic [1:0] DIR_FWD     = 2'd1;
    localparam logic [1:0] DIR_REV     = 2'd2;
    localparam logic [1:0] DIR_INVALID = 2'd3;

    localparam logic [1:0] POS_LOW  = 2'd0;
    localparam logic [1:0] POS_HIGH = 2'd1;
    localparam logic [1:0] POS_CODE = 2'd2;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [15:0] count;
        logic [7:0]  code;
    } t_cmd;

    typedef struct packed {
        logic [3:0] phase;
        logic       led_clear;
        logic       last;
    } t_result;

    function automatic logic [1:0] dir_of(input logic [7:0] code);
        logic [1:0] d;
        if (code == CODE_FWD) begin
            d = DIR_FWD;
        end else if (code == CODE_REV) begin
            d = DIR_REV;
        end else begin
            d = DIR_INVALID;
        end
        return d;
    endfunction

    // Wave drive order: forward 1,4,2,8; reverse walks the same table backward.
    function automatic logic [3:0] phase_word(input logic rev, input logic [1:0] idx);
        logic [1:0] k;
        logic [3:0] w;
        k = rev ? ~idx : idx;
        case (k)
            2'd0:    w = 4'h1;
            2'd1:    w = 4'h4;
            2'd2:    w = 4'h2;
            default: w = 4'h8;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/stepper_phase_command_sequencer_top.sv
// Stepper wave-drive command sequencer.
// Input stream (s_axis): each beat is either a received command byte
// (tuser = 0) or a phase tick (tuser = 1). A command is three byte beats:
// step count low byte, high byte, direction code. halt_level in tdata is
// sampled when a command starts; 0 drops the command.
// Output stream (m_axis): one beat per tick while a move runs, carrying the
// coil phase word; tlast marks the final phase of the command and tuser
// flags an LED clear for an invalid direction code.
// A tick's result is registered in the output or skid register before it
// appears on m_axis. Throughput: one input beat per cycle while
// s_axis_tready is high; the sequencer's next-state logic is combinational.
// A two-entry output stage (output register plus skid register) lets the
// block keep taking beats while a result waits; if the receiver stalls with
// both entries full, s_axis_tready drops until a beat drains.
// Reset (synchronous, active low) clears the byte position, the move in
// progress, the pending command slot and any buffered results.
module stepper_phase_command_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] rx_byte, [8] halt_level
    input  logic        i_s_axis_tuser,   // [0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [3:0] phase_pattern
    output logic        o_m_axis_tuser,   // [0] led_clear
    output logic        o_m_axis_tlast
);
    import spcs_pkg::*;

    logic    in_beat;
    t_cmd    cmd;
    logic    res_valid;
    t_result res, out_res;

    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;

    spcs_cmd_assembler u_asm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_beat (in_beat && (i_s_axis_tuser == REQ_BYTE)),
        .i_rx_byte   (i_s_axis_tdata[7:0]),
        .o_cmd       (cmd)
    );

    spcs_phase_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_beat),
        .i_req_type   (i_s_axis_tuser),
        .i_halt_level (i_s_axis_tdata[8]),
        .i_cmd        (cmd),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    spcs_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {4'b0000, out_res.phase};
    assign o_m_axis_tuser = out_res.led_clear;
    assign o_m_axis_tlast = out_res.last;

endmodule

FILE: rtl/spcs_cmd_assembler.sv
module spcs_cmd_assembler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_byte_beat,
    input  logic [7:0]    i_rx_byte,
    output spcs_pkg::t_cmd o_cmd
);
    import spcs_pkg::*;

    logic [1:0] r_pos, n_pos;
    logic [7:0] r_low, n_low;
    logic [7:0] r_high, n_high;

    always_comb begin
        n_pos  = r_pos;
        n_low  = r_low;
        n_high = r_high;
        o_cmd  = '0;
        if (i_byte_beat) begin
            unique case (r_pos)
                POS_HIGH: begin
                    n_high = i_rx_byte;
                    n_pos  = POS_CODE;
                end
                POS_CODE: begin
                    n_pos       = POS_LOW;
                    o_cmd.valid = 1'b1;
                    o_cmd.count = {r_high, r_low};
                    o_cmd.code  = i_rx_byte;
                end
                default: begin
                    n_low = i_rx_byte;
                    n_pos = POS_HIGH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_LOW;
            r_low  <= '0;
            r_high <= '0;
        end else begin
            r_pos  <= n_pos;
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

endmodule

FILE: rtl/spcs_phase_sequencer.sv
module spcs_phase_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_req_type,
    input  logic              i_halt_level,
    input  spcs_pkg::t_cmd    i_cmd,
    output logic              o_res_valid,
    output spcs_pkg::t_result o_res
);
    import spcs_pkg::*;

    logic        r_run_active, n_run_active;
    logic [1:0]  r_dir, n_dir;
    logic [15:0] r_steps, n_steps;
    logic [1:0]  r_phase, n_phase;
    logic        r_pend_valid, n_pend_valid;
    logic [15:0] r_pend_count, n_pend_count;
    logic [7:0]  r_pend_code, n_pend_code;

    logic        eff_active;
    logic [1:0]  eff_dir;
    logic [15:0] eff_steps;
    logic [1:0]  eff_phase;

    always_comb begin
        n_run_active = r_run_active;
        n_dir        = r_dir;
        n_steps      = r_steps;
        n_phase      = r_phase;
        n_pend_valid = r_pend_valid;
        n_pend_count = r_pend_count;
        n_pend_code  = r_pend_code;
        eff_active   = r_run_active;
        eff_dir      = r_dir;
        eff_steps    = r_steps;
        eff_phase    = r_phase;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_accept) begin
            if (i_req_type == REQ_BYTE) begin
                if (i_cmd.valid) begin
                    if (r_run_active) begin
                        // one pending slot; a further command is dropped
                        if (!r_pend_valid) begin
                            n_pend_valid = 1'b1;
                            n_pend_count = i_cmd.count;
                            n_pend_code  = i_cmd.code;
                        end
                    end else if (i_halt_level) begin
                        n_run_active = 1'b1;
                        n_phase      = 2'd0;
                        n_steps      = i_cmd.count;
                        n_dir        = dir_of(i_cmd.code);
                    end
                end
            end else begin
                // start the pending command on this tick; halt sampled from the tick
                if (!r_run_active && r_pend_valid) begin
                    n_pend_valid = 1'b0;
                    if (i_halt_level) begin
                        eff_active = 1'b1;
                        eff_phase  = 2'd0;
                        eff_steps  = r_pend_count;
                        eff_dir    = dir_of(r_pend_code);
                    end
                end
                n_run_active = eff_active;
                n_dir        = eff_dir;
                n_steps      = eff_steps;
                n_phase      = eff_phase;
                if (eff_active) begin
                    o_res_valid = 1'b1;
                    if (eff_dir != DIR_FWD && eff_dir != DIR_REV) begin
                        o_res.led_clear = 1'b1;
                        o_res.last      = 1'b1;
                        n_run_active    = 1'b0;
                    end else begin
                        o_res.phase = phase_word(eff_dir == DIR_REV, eff_phase);
                        n_phase     = eff_phase + 2'd1;
                        if (eff_phase == 2'd3) begin
                            if (eff_steps == '0) begin
                                o_res.last   = 1'b1;
                                n_run_active = 1'b0;
                            end else begin
                                n_steps = eff_steps - 16'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active <= 1'b0;
            r_dir        <= DIR_NONE;
            r_steps      <= '0;
            r_phase      <= '0;
            r_pend_valid <= 1'b0;
            r_pend_count <= '0;
            r_pend_code  <= '0;
        end else begin
            r_run_active <= n_run_active;
            r_dir        <= n_dir;
            r_steps      <= n_steps;
            r_phase      <= n_phase;
            r_pend_valid <= n_pend_valid;
            r_pend_count <= n_pend_count;
            r_pend_code  <= n_pend_code;
        end
    end

endmodule

FILE: rtl/spcs_out_skid.sv
module spcs_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spcs_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    output spcs_pkg::t_result o_res,
    input  logic              i_ready
);
    import spcs_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            // advance: skid beat first, else the new beat
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

FILE: test/spcs_phase_checker.sv
module spcs_phase_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] rx_byte, [8] halt_level
    input  logic        i_s_tuser,   // [0] req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [3:0] phase_pattern
    input  logic        i_m_tuser,   // [0] led_clear
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_awaiting
);
    import spcs_pkg::*;

    logic [1:0]  byte_pos;
    logic [7:0]  count_lo;
    logic [7:0]  count_hi;
    logic        moving;
    logic [1:0]  move_dir;
    logic [16:0] steps_to_go;
    logic [1:0]  phase_at;
    logic        held_valid;
    logic [15:0] held_count;
    logic [7:0]  held_code;
    t_result     phase_expect[$];

    function automatic logic [3:0] wave_word(input logic [1:0] dir, input logic [1:0] idx);
        logic [3:0] w;
        if (dir == DIR_REV) begin
            case (idx)
                2'd0:    w = 4'h8;
                2'd1:    w = 4'h2;
                2'd2:    w = 4'h4;
                default: w = 4'h1;
            endcase
        end else begin
            case (idx)
                2'd0:    w = 4'h1;
                2'd1:    w = 4'h4;
                2'd2:    w = 4'h2;
                default: w = 4'h8;
            endcase
        end
        return w;
    endfunction

    // Halt low at start drops the command outright.
    task automatic launch_move(input logic [15:0] count, input logic [7:0] code,
                               input logic halt);
        if (halt) begin
            moving      = 1'b1;
            phase_at    = 2'd0;
            steps_to_go = {1'b0, count};
            if (code == CODE_FWD) begin
                move_dir = DIR_FWD;
            end else if (code == CODE_REV) begin
                move_dir = DIR_REV;
            end else begin
                move_dir = DIR_INVALID;
            end
        end
    endtask

    task automatic take_beat(input logic req, input logic [7:0] rx, input logic halt);
        t_result r;
        if (req == REQ_BYTE) begin
            case (byte_pos)
                POS_HIGH: begin
                    count_hi = rx;
                    byte_pos = POS_CODE;
                end
                POS_CODE: begin
                    byte_pos = POS_LOW;
                    if (moving) begin
                        // one pending slot; a further command is dropped
                        if (!held_valid) begin
                            held_valid = 1'b1;
                            held_count = {count_hi, count_lo};
                            held_code  = rx;
                        end
                    end else begin
                        launch_move({count_hi, count_lo}, rx, halt);
                    end
                end
                default: begin
                    count_lo = rx;
                    byte_pos = POS_HIGH;
                end
            endcase
        end else begin
            if (!moving && held_valid) begin
                held_valid = 1'b0;
                launch_move(held_count, held_code, halt);
            end
            if (moving) begin
                if (move_dir != DIR_FWD && move_dir != DIR_REV) begin
                    r.phase     = 4'h0;
                    r.led_clear = 1'b1;
                    r.last      = 1'b1;
                    moving      = 1'b0;
                end else begin
                    r.phase     = wave_word(move_dir, phase_at);
                    r.led_clear = 1'b0;
                    r.last      = 1'b0;
                    if (phase_at == 2'd3) begin
                        phase_at = 2'd0;
                        if (steps_to_go == 17'd0) begin
                            r.last = 1'b1;
                            moving = 1'b0;
                        end else begin
                            steps_to_go = steps_to_go - 17'd1;
                        end
                    end else begin
                        phase_at = phase_at + 2'd1;
                    end
                end
                phase_expect.push_back(r);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        int      bad;
        bad = 0;
        if (!i_rst_n) begin
            byte_pos    = POS_LOW;
            count_lo    = '0;
            count_hi    = '0;
            moving      = 1'b0;
            move_dir    = DIR_NONE;
            steps_to_go = '0;
            phase_at    = '0;
            held_valid  = 1'b0;
            held_count  = '0;
            held_code   = '0;
            phase_expect.delete();
            o_mismatches <= 0;
            o_awaiting   <= 0;
        end else begin
            // drain first: a result beat always belongs to an earlier tick
            if (i_m_tvalid && i_m_tready) begin
                if (phase_expect.size() == 0) begin
                    $display("%0t: extra beat, expected none, actual tdata=%h tuser=%b tlast=%b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    bad++;
                end else begin
                    want = phase_expect.pop_front();
                    if (i_m_tdata !== {4'b0000, want.phase}) begin
                        $display("%0t: phase_pattern expected %h actual %h",
                                 $time, {4'b0000, want.phase}, i_m_tdata);
                        bad++;
                    end
                    if (i_m_tuser !== want.led_clear) begin
                        $display("%0t: led_clear expected %b actual %b",
                                 $time, want.led_clear, i_m_tuser);
                        bad++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.last, i_m_tlast);
                        bad++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                take_beat(i_s_tuser, i_s_tdata[7:0], i_s_tdata[8]);
            end
            o_mismatches <= o_mismatches + bad;
            o_awaiting   <= phase_expect.size();
        end
    end

endmodule

FILE: test/tb_stepper_phase_command_sequencer_top.sv
module tb_stepper_phase_command_sequencer_top;
    import spcs_pkg::*;

    localparam int STALL_LIMIT = 1000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] rx_byte, [8] halt_level
    logic        s_tuser  = 1'b0; // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [3:0] phase_pattern
    logic        m_tuser;         // [0] led_clear
    logic        m_tlast;

    int          mismatches;
    int          awaiting;
    int          beats_sent = 0;
    int          byte_slot  = 0;
    int          quiet_cycles = 0;
    int unsigned stall_left = 0;
    logic        idle_on = 1'b1;

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    stepper_phase_command_sequencer_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    spcs_phase_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_awaiting   (awaiting)
    );

    // Receiver stalls at random, in bursts, while idle_on is set.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_stepper_phase_command_sequencer_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic req, input logic [7:0] rx, input logic halt);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, halt, rx};
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        beats_sent++;
        if (req == REQ_BYTE) begin
            byte_slot = (byte_slot == 2) ? 0 : byte_slot + 1;
        end
    endtask

    task automatic send_command(input logic [15:0] count, input logic [7:0] code,
                                input logic halt);
        send_beat(REQ_BYTE, count[7:0], 1'($urandom_range(0, 1)));
        send_beat(REQ_BYTE, count[15:8], 1'($urandom_range(0, 1)));
        send_beat(REQ_BYTE, code, halt);
    endtask

    task automatic send_ticks(input int n, input logic halt);
        for (int k = 0; k < n; k++) begin
            send_beat(REQ_TICK, 8'($urandom), halt);
        end
    endtask

    function automatic logic [7:0] bad_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CODE_FWD || c == CODE_REV);
        return c;
    endfunction

    initial begin
        int         pick;
        int         directed_end;
        int         quiet_from;
        logic [7:0] code;
        logic [15:0] count;
        logic       halt;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick with nothing to run
        send_ticks(1, 1'b1);
        // shortest forward and reverse moves
        send_command(16'h0000, CODE_FWD, 1'b1);
        send_ticks(4, 1'b1);
        send_command(16'h0000, CODE_REV, 1'b1);
        send_ticks(4, 1'b1);
        // invalid direction ignores a full count
        send_command(16'hFFFF, 8'h00, 1'b1);
        send_ticks(1, 1'b0);
        // halt low drops the command
        send_command(16'h0000, CODE_FWD, 1'b0);
        send_ticks(1, 1'b1);

        directed_end = beats_sent;
        quiet_from   = directed_end + 1500;
        while (beats_sent < directed_end + 1750) begin
            idle_on = (beats_sent < quiet_from) && (((beats_sent / 150) % 4) != 3);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // realign after noise: finish the broken command with a bad code
                if (byte_slot == 1) begin
                    send_beat(REQ_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
                end
                if (byte_slot == 2) begin
                    send_beat(REQ_BYTE, bad_code(), 1'($urandom_range(0, 1)));
                end
                halt = ($urandom_range(0, 6) != 0);
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    code = CODE_FWD;
                end else if (pick < 80) begin
                    code = CODE_REV;
                end else begin
                    code = bad_code();
                end
                if (code != CODE_FWD && code != CODE_REV) begin
                    count = 16'($urandom);
                end else if ($urandom_range(0, 9) == 0) begin
                    count = 16'($urandom_range(0, 15));
                end else begin
                    count = 16'($urandom_range(0, 3));
                end
                send_command(count, code, halt);
            end else if (pick < 90) begin
                send_ticks($urandom_range(1, 10), $urandom_range(0, 9) != 0);
            end else begin
                // stray bytes; never complete a command here
                for (int k = $urandom_range(1, 2); k > 0; k--) begin
                    if (byte_slot != 2) begin
                        send_beat(REQ_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
                    end
                end
            end
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;

        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && awaiting == 0) begin
            $display("tb_stepper_phase_command_sequencer_top OK");
        end else begin
            $display("tb_stepper_phase_command_sequencer_top NOT OK");
        end
        $finish;
    end

endmodule
